[rtl/i2t_pkg.sv]
// ----------------------------------------------------------------------------
// i2t_pkg: shared definitions for the integer to padded text formatter
// Sizes, base codes, ASCII codes and the job record that the front part
// hands to the back part through the queue.
// ----------------------------------------------------------------------------
package i2t_pkg;

  // Largest field width and precision, and the number of magnitude bits used.
  localparam int MAX_FIELD  = 60;
  localparam int VALUE_BITS = 64;

  // Digit slots: octal needs the most digits of all bases.
  localparam int NUM_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int DIG_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  // Length arithmetic width: holds a full field and the raw 7-bit inputs.
  localparam int LEN_W = $clog2(MAX_FIELD + 3);
  localparam int AW    = (LEN_W > 7) ? LEN_W : 7;

  // Base codes of base_select.
  localparam logic [1:0] BASE_OCT     = 2'd0;
  localparam logic [1:0] BASE_DEC     = 2'd1;
  localparam logic [1:0] BASE_HEX     = 2'd2;
  localparam logic [1:0] BASE_HEX_ALT = 2'd3;

  // ASCII codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  // One formatted field, described by its segment boundaries.
  // Positions below b1 are spaces, then the prefix up to b2, zeros up to b3,
  // digits up to b4 and trailing spaces up to len.
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic                       upper;
    logic [7:0]                 prefix0;
    logic [7:0]                 prefix1;
    logic [AW-1:0]              b1;
    logic [AW-1:0]              b2;
    logic [AW-1:0]              b3;
    logic [AW-1:0]              b4;
    logic [AW-1:0]              len;
  } job_t;

endpackage

[rtl/i2t_front.sv]
// ----------------------------------------------------------------------------
// i2t_front: conversion front end
// Accepts one conversion, extracts its digits (double dabble for decimal,
// direct bit fields for octal and hex), finds the digit count and works out
// the field layout, then queues one job unless the field is empty.
// ----------------------------------------------------------------------------
module i2t_front import i2t_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] magnitude,
  input  logic        signed_conv,
  input  logic        is_negative,
  input  logic [1:0]  base_select,
  input  logic        upper_case,
  input  logic        left_justify,
  input  logic        zero_pad,
  input  logic        force_plus,
  input  logic        space_sign,
  input  logic        alternate,
  input  logic [5:0]  field_width,
  input  logic [6:0]  min_digits,
  output logic        q_push,
  output job_t        q_data,
  input  logic        q_full
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DABBLE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_PUSH   = 2'd3;

  localparam logic [AW-1:0]    MAX_A   = AW'(MAX_FIELD);
  localparam logic [DIG_W-1:0] TOP_IDX = DIG_W'(NUM_DIGITS - 1);

  logic [1:0] state;

  // Item registers.
  logic [NUM_DIGITS-1:0][3:0] digits;
  logic [VALUE_BITS-1:0]      shreg;
  logic [CNT_W-1:0]           cnt;
  logic [DIG_W-1:0]           idx;
  logic                       vzero;
  logic                       sgn;
  logic                       neg;
  logic [1:0]                 sel;
  logic                       upper;
  logic                       left;
  logic                       zero;
  logic                       plus;
  logic                       space;
  logic                       alt;
  logic [AW-1:0]              width;
  logic [6:0]                 prec_in;

  // Digit sources at accept time.
  logic [VALUE_BITS-1:0]       value;
  logic [3*NUM_DIGITS-1:0]     oct_src;
  logic [NUM_DIGITS-1:0][3:0]  oct_digits;
  logic [NUM_DIGITS-1:0][3:0]  hex_digits;
  logic [1:0]                  sel_in;
  logic [AW-1:0]               width_raw;

  // Double dabble adjust.
  logic [NUM_DIGITS-1:0][3:0]  adj;
  logic [4*NUM_DIGITS-1:0]     adj_flat;

  // Layout arithmetic.
  logic          prec_set;
  logic [AW-1:0] prec_raw;
  logic [AW-1:0] prec;
  logic [AW-1:0] nd;
  logic [AW-1:0] nd_eff;
  logic [AW-1:0] np;
  logic [7:0]    pre0;
  logic [7:0]    pre1;
  logic [AW-1:0] zeros;
  logic          zfill;
  logic [AW-1:0] content;
  logic [AW-1:0] pad;
  logic [AW-1:0] b1;
  logic [AW-1:0] b2;
  logic [AW-1:0] b3;
  logic [AW-1:0] b4;
  logic [AW-1:0] len;

  assign in_stall = (state != ST_IDLE);

  // Digit fields of the incoming magnitude.
  assign value      = magnitude[VALUE_BITS-1:0];
  assign oct_src    = (3*NUM_DIGITS)'(value);
  assign hex_digits = (4*NUM_DIGITS)'(value);
  assign sel_in     = (base_select == BASE_HEX_ALT) ? BASE_HEX : base_select;
  assign width_raw  = AW'(field_width);

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      oct_digits[i] = {1'b0, oct_src[3*i +: 3]};
    end
  end

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end
  assign adj_flat = adj;

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= (sel_in == BASE_DEC) ? ST_DABBLE : ST_SCAN;
          end
        end
        ST_DABBLE: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!(idx != '0 && digits[idx] == 4'd0)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (len == '0 || !q_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item registers: loaded on the transfer, then stepped by the sequence.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (in_valid) begin
        shreg   <= value;
        cnt     <= CNT_W'(VALUE_BITS);
        idx     <= TOP_IDX;
        vzero   <= (value == '0);
        sgn     <= signed_conv;
        neg     <= is_negative;
        sel     <= sel_in;
        upper   <= upper_case;
        left    <= left_justify;
        zero    <= zero_pad;
        plus    <= force_plus;
        space   <= space_sign;
        alt     <= alternate;
        width   <= (width_raw > MAX_A) ? MAX_A : width_raw;
        prec_in <= min_digits;
        if (sel_in == BASE_DEC) begin
          digits <= '0;
        end else if (sel_in == BASE_OCT) begin
          digits <= oct_digits;
        end else begin
          digits <= hex_digits;
        end
      end
    end else if (state == ST_DABBLE) begin
      digits <= {adj_flat[4*NUM_DIGITS-2:0], shreg[VALUE_BITS-1]};
      shreg  <= {shreg[VALUE_BITS-2:0], 1'b0};
      cnt    <= cnt - CNT_W'(1);
    end else if (state == ST_SCAN) begin
      if (idx != '0 && digits[idx] == 4'd0) begin
        idx <= idx - DIG_W'(1);
      end
    end
  end

  // Prefix selection.
  always_comb begin
    np   = '0;
    pre0 = CH_ZERO;
    pre1 = CH_X_LO;
    if (sgn) begin
      if (neg) begin
        np   = AW'(1);
        pre0 = CH_MINUS;
      end else if (plus) begin
        np   = AW'(1);
        pre0 = CH_PLUS;
      end else if (space) begin
        np   = AW'(1);
        pre0 = CH_SPACE;
      end
    end else if (alt && !vzero) begin
      if (sel == BASE_OCT) begin
        np = AW'(1);
      end else if (sel == BASE_HEX) begin
        np   = AW'(2);
        pre1 = upper ? CH_X_UP : CH_X_LO;
      end
    end
  end

  // Field layout from precision, width and digit count.
  always_comb begin
    prec_set = ~prec_in[6];
    prec_raw = AW'(prec_in[5:0]);
    if (!prec_set) begin
      prec = '0;
    end else begin
      prec = (prec_raw > MAX_A) ? MAX_A : prec_raw;
    end
    nd      = AW'(idx) + AW'(1);
    zeros   = (prec_set && prec > nd) ? prec - nd : '0;
    zfill   = !prec_set && zero && !left && (width != '0);
    nd_eff  = (vzero && prec_set && prec == '0) ? '0 : nd;
    content = np + zeros + nd_eff;
    pad     = (width > content) ? width - content : '0;
    b1      = (!left && !zfill) ? pad : '0;
    b2      = b1 + np;
    b3      = b2 + zeros + (zfill ? pad : '0);
    b4      = b3 + nd_eff;
    len     = b4 + (left ? pad : '0);
  end

  // Queue write; an empty field is dropped here.
  assign q_push = (state == ST_PUSH) && (len != '0) && !q_full;

  always_comb begin
    q_data.digits  = digits;
    q_data.upper   = upper;
    q_data.prefix0 = pre0;
    q_data.prefix1 = pre1;
    q_data.b1      = b1;
    q_data.b2      = b2;
    q_data.b3      = b3;
    q_data.b4      = b4;
    q_data.len     = len;
  end

endmodule

[rtl/i2t_queue.sv]
// ----------------------------------------------------------------------------
// i2t_queue: job queue between front and back
// A two-entry register queue so that digit extraction of the next item can
// overlap the character output of the current one.
// ----------------------------------------------------------------------------
module i2t_queue import i2t_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  job_t       wr_data,
  output logic       full,
  input  logic       pop,
  output logic       rd_valid,
  output job_t       rd_data,
  output logic [1:0] count
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;

  assign full     = (count == 2'(DEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

[rtl/i2t_back.sv]
// ----------------------------------------------------------------------------
// i2t_back: character output back end
// Takes one job from the queue and walks its positions, one character a cycle
// unless the output stalls, into an output register that the receiver drains.
// ----------------------------------------------------------------------------
module i2t_back import i2t_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] character,
  output logic       last
);

  job_t          job;
  logic          busy;
  logic [AW-1:0] pos;

  logic          emit;
  logic          at_end;
  logic [AW-1:0] dpos;
  logic [3:0]    dval;
  logic [7:0]    dchar;
  logic [7:0]    ch;

  assign q_pop  = !busy && q_valid;
  assign emit   = busy && (!out_valid || !out_stall);
  assign at_end = (pos == job.len - AW'(1));

  // Digits are stored least significant first.
  assign dpos  = job.b4 - AW'(1) - pos;
  assign dval  = job.digits[dpos[DIG_W-1:0]];
  assign dchar = (dval < 4'd10) ? CH_ZERO + {4'd0, dval}
               : (job.upper ? CH_A_UP : CH_A_LO) + {4'd0, dval} - 8'd10;

  // Character at the current position.
  always_comb begin
    if (pos < job.b1) begin
      ch = CH_SPACE;
    end else if (pos < job.b2) begin
      ch = (pos == job.b1) ? job.prefix0 : job.prefix1;
    end else if (pos < job.b3) begin
      ch = CH_ZERO;
    end else if (pos < job.b4) begin
      ch = dchar;
    end else begin
      ch = CH_SPACE;
    end
  end

  // Job and output control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && at_end) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Job payload, position and output register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
      pos <= '0;
    end else if (emit) begin
      pos <= pos + AW'(1);
    end
    if (emit) begin
      character <= ch;
      last      <= at_end;
    end
  end

endmodule

[rtl/integer_to_padded_text.sv]
// ----------------------------------------------------------------------------
// integer_to_padded_text: printf-style integer field formatter
// Turns one integer conversion request into its ASCII field, one character
// per result, with last marking the final character.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  ------------------------------------------
//   input    in_valid / in_stall   magnitude, flags, field_width, min_digits
//   output   out_valid / out_stall character, last
//
// Front: takes the transfer, runs double dabble for decimal, scans for the
// digit count and writes the queue, waiting while the queue is full.
// Back: takes a job, then one character per cycle (up to 62) unless stalled.
// A two-entry queue lets the next conversion overlap the current output.
// Reset is synchronous and clears the sequencers and the queue only.
// A stalled output holds its character; the back part waits behind it.
// ----------------------------------------------------------------------------
module integer_to_padded_text import i2t_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] magnitude,
  input  logic        signed_conv,
  input  logic        is_negative,
  input  logic [1:0]  base_select,
  input  logic        upper_case,
  input  logic        left_justify,
  input  logic        zero_pad,
  input  logic        force_plus,
  input  logic        space_sign,
  input  logic        alternate,
  input  logic [5:0]  field_width,
  input  logic [6:0]  min_digits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic        last
);

  logic       q_push;
  job_t       q_wdata;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  job_t       q_rdata;
  logic [1:0] q_count;

  // Digit extraction and layout.
  i2t_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .magnitude    (magnitude),
    .signed_conv  (signed_conv),
    .is_negative  (is_negative),
    .base_select  (base_select),
    .upper_case   (upper_case),
    .left_justify (left_justify),
    .zero_pad     (zero_pad),
    .force_plus   (force_plus),
    .space_sign   (space_sign),
    .alternate    (alternate),
    .field_width  (field_width),
    .min_digits   (min_digits),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  // Job queue.
  i2t_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata),
    .count    (q_count)
  );

  // Character output.
  i2t_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  // The queue never holds more than its two entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (q_count != 2'd3))
    else $error("job queue count out of range");

  // A full queue is never written.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count != 2'd2))
    else $error("job queue written while full");

  // After an input transfer the front part is busy on the next cycle.
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front part took a second item at once");

  // Within a field the characters follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("gap inside a field");

endmodule
